[sv/caf_pkg.sv]
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types and constants for the ALU and flag unit: operation codes,
// decoded operation classes, flag positions and the queue entry format.
// ----------------------------------------------------------------------------
package caf_pkg;

  typedef enum logic [4:0] {
    F_ADC = 5'd0,  F_SBC = 5'd1,  F_AND = 5'd2,  F_ORA = 5'd3,
    F_EOR = 5'd4,  F_BIT = 5'd5,  F_CMP = 5'd6,  F_CPX = 5'd7,
    F_CPY = 5'd8,  F_LDA = 5'd9,  F_LDX = 5'd10, F_LDY = 5'd11,
    F_LAX = 5'd12, F_ASL = 5'd13, F_LSR = 5'd14, F_ROL = 5'd15,
    F_ROR = 5'd16, F_INC = 5'd17, F_DEC = 5'd18, F_DCP = 5'd19,
    F_ISB = 5'd20, F_SLO = 5'd21, F_SRE = 5'd22, F_RLA = 5'd23,
    F_RRA = 5'd24, F_STA = 5'd25, F_STX = 5'd26, F_STY = 5'd27,
    F_CLF = 5'd28, F_SEF = 5'd29
  } func_t;

  // memory-side modify step
  typedef enum logic [2:0] {
    PRE_NONE, PRE_ASL, PRE_LSR, PRE_ROL, PRE_ROR, PRE_INC, PRE_DEC
  } pre_op_t;

  // register-side step, applied to the (possibly modified) byte
  typedef enum logic [3:0] {
    POST_NONE, POST_ADC, POST_SBC, POST_AND, POST_ORA, POST_EOR, POST_BIT,
    POST_CMP, POST_LD, POST_ST, POST_CLF, POST_SEF
  } post_op_t;

  typedef enum logic [1:0] {
    REG_A, REG_X, REG_Y, REG_AX
  } reg_sel_t;

  typedef struct packed {
    pre_op_t  pre;
    logic     pre_zn;
    post_op_t post;
    reg_sel_t reg_sel;
    logic     mem_wr;
  } dec_t;

  typedef struct packed {
    dec_t       dec;
    logic [7:0] operand;
    logic [2:0] fsel;
  } qent_t;

  localparam logic [2:0] FLAG_C = 3'd0;
  localparam logic [2:0] FLAG_Z = 3'd1;
  localparam logic [2:0] FLAG_V = 3'd6;
  localparam logic [2:0] FLAG_N = 3'd7;

  localparam logic [7:0] STATUS_RESET = 8'h24;

endpackage

[sv/caf_ifs.sv]
// ----------------------------------------------------------------------------
// caf_ifs
// Request channels of the ALU and flag unit: operation in, result out.
// ----------------------------------------------------------------------------
interface caf_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] func;
  logic [7:0] operand_byte;
  logic [2:0] flag_select;

  modport source(output valid, func, operand_byte, flag_select, input ready);
  modport sink(input valid, func, operand_byte, flag_select, output ready);
endinterface

interface caf_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] write_data;
  logic [7:0] acc_value;
  logic [7:0] x_value;
  logic [7:0] y_value;
  logic [7:0] status_value;

  modport source(output valid, write_enable, write_data, acc_value, x_value,
                 y_value, status_value, input ready);
  modport sink(input valid, write_enable, write_data, acc_value, x_value,
               y_value, status_value, output ready);
endinterface

[sv/caf_front.sv]
// ----------------------------------------------------------------------------
// caf_front
// Accepts requests and classifies the operation code into a modify step,
// a register step, a register select and a memory write flag.
// ----------------------------------------------------------------------------
module caf_front (
  caf_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output caf_pkg::qent_t  push_data
);

  caf_pkg::dec_t dec;

  always_comb begin
    dec.pre     = caf_pkg::PRE_NONE;
    dec.pre_zn  = 1'b0;
    dec.post    = caf_pkg::POST_NONE;
    dec.reg_sel = caf_pkg::REG_A;
    dec.mem_wr  = 1'b0;
    unique case (in_ch.func)
      caf_pkg::F_ADC: dec.post = caf_pkg::POST_ADC;
      caf_pkg::F_SBC: dec.post = caf_pkg::POST_SBC;
      caf_pkg::F_AND: dec.post = caf_pkg::POST_AND;
      caf_pkg::F_ORA: dec.post = caf_pkg::POST_ORA;
      caf_pkg::F_EOR: dec.post = caf_pkg::POST_EOR;
      caf_pkg::F_BIT: dec.post = caf_pkg::POST_BIT;
      caf_pkg::F_CMP: dec.post = caf_pkg::POST_CMP;
      caf_pkg::F_CPX: begin
        dec.post = caf_pkg::POST_CMP; dec.reg_sel = caf_pkg::REG_X;
      end
      caf_pkg::F_CPY: begin
        dec.post = caf_pkg::POST_CMP; dec.reg_sel = caf_pkg::REG_Y;
      end
      caf_pkg::F_LDA: dec.post = caf_pkg::POST_LD;
      caf_pkg::F_LDX: begin
        dec.post = caf_pkg::POST_LD; dec.reg_sel = caf_pkg::REG_X;
      end
      caf_pkg::F_LDY: begin
        dec.post = caf_pkg::POST_LD; dec.reg_sel = caf_pkg::REG_Y;
      end
      caf_pkg::F_LAX: begin
        dec.post = caf_pkg::POST_LD; dec.reg_sel = caf_pkg::REG_AX;
      end
      caf_pkg::F_ASL: begin
        dec.pre = caf_pkg::PRE_ASL; dec.pre_zn = 1'b1; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_LSR: begin
        dec.pre = caf_pkg::PRE_LSR; dec.pre_zn = 1'b1; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_ROL: begin
        dec.pre = caf_pkg::PRE_ROL; dec.pre_zn = 1'b1; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_ROR: begin
        dec.pre = caf_pkg::PRE_ROR; dec.pre_zn = 1'b1; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_INC: begin
        dec.pre = caf_pkg::PRE_INC; dec.pre_zn = 1'b1; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_DEC: begin
        dec.pre = caf_pkg::PRE_DEC; dec.pre_zn = 1'b1; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_DCP: begin
        dec.pre = caf_pkg::PRE_DEC; dec.post = caf_pkg::POST_CMP;
        dec.mem_wr = 1'b1;
      end
      caf_pkg::F_ISB: begin
        dec.pre = caf_pkg::PRE_INC; dec.post = caf_pkg::POST_SBC;
        dec.mem_wr = 1'b1;
      end
      caf_pkg::F_SLO: begin
        dec.pre = caf_pkg::PRE_ASL; dec.pre_zn = 1'b1;
        dec.post = caf_pkg::POST_ORA; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_SRE: begin
        dec.pre = caf_pkg::PRE_LSR; dec.pre_zn = 1'b1;
        dec.post = caf_pkg::POST_EOR; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_RLA: begin
        dec.pre = caf_pkg::PRE_ROL; dec.pre_zn = 1'b1;
        dec.post = caf_pkg::POST_AND; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_RRA: begin
        dec.pre = caf_pkg::PRE_ROR; dec.pre_zn = 1'b1;
        dec.post = caf_pkg::POST_ADC; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_STA: begin
        dec.post = caf_pkg::POST_ST; dec.mem_wr = 1'b1;
      end
      caf_pkg::F_STX: begin
        dec.post = caf_pkg::POST_ST; dec.reg_sel = caf_pkg::REG_X;
        dec.mem_wr = 1'b1;
      end
      caf_pkg::F_STY: begin
        dec.post = caf_pkg::POST_ST; dec.reg_sel = caf_pkg::REG_Y;
        dec.mem_wr = 1'b1;
      end
      caf_pkg::F_CLF: dec.post = caf_pkg::POST_CLF;
      caf_pkg::F_SEF: dec.post = caf_pkg::POST_SEF;
      default: ;
    endcase
  end

  assign push_valid        = in_ch.valid;
  assign in_ch.ready       = push_ready;
  assign push_data.dec     = dec;
  assign push_data.operand = in_ch.operand_byte;
  assign push_data.fsel    = in_ch.flag_select;

endmodule

[sv/caf_queue.sv]
// ----------------------------------------------------------------------------
// caf_queue
// Two-entry request queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module caf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  caf_pkg::qent_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output caf_pkg::qent_t  pop_data
);

  caf_pkg::qent_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/caf_back.sv]
// ----------------------------------------------------------------------------
// caf_back
// Execute stage: holds A, X, Y and the status flags, runs the modify and
// register steps of the queue head and registers the result.
// ----------------------------------------------------------------------------
module caf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  caf_pkg::qent_t  pop_data,
  caf_out_if.source       out_ch
);

  logic [7:0] acc_r, acc_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic [7:0] p_r, p_nxt;
  logic       ov_r;
  logic       we_r, we_nxt;
  logic [7:0] wd_r, wd_nxt;

  logic       fire;
  logic [7:0] m, mod, reg_v, addend, res;
  logic [8:0] sum;
  logic [8:0] diff;
  caf_pkg::dec_t dec;

  assign dec       = pop_data.dec;
  assign m         = pop_data.operand;
  assign pop_ready = !ov_r || out_ch.ready;
  assign fire      = pop_valid && pop_ready;

  always_comb begin
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    p_nxt   = p_r;
    mod     = m;
    res     = 8'h00;

    case (dec.pre)
      caf_pkg::PRE_ASL: begin
        mod = {m[6:0], 1'b0};     p_nxt[caf_pkg::FLAG_C] = m[7];
      end
      caf_pkg::PRE_LSR: begin
        mod = {1'b0, m[7:1]};     p_nxt[caf_pkg::FLAG_C] = m[0];
      end
      caf_pkg::PRE_ROL: begin
        mod = {m[6:0], p_r[caf_pkg::FLAG_C]}; p_nxt[caf_pkg::FLAG_C] = m[7];
      end
      caf_pkg::PRE_ROR: begin
        mod = {p_r[caf_pkg::FLAG_C], m[7:1]}; p_nxt[caf_pkg::FLAG_C] = m[0];
      end
      caf_pkg::PRE_INC: mod = m + 8'd1;
      caf_pkg::PRE_DEC: mod = m - 8'd1;
      default: ;
    endcase
    if (dec.pre_zn) begin
      p_nxt[caf_pkg::FLAG_Z] = (mod == 8'h00);
      p_nxt[caf_pkg::FLAG_N] = mod[7];
    end

    case (dec.reg_sel)
      caf_pkg::REG_X: reg_v = x_r;
      caf_pkg::REG_Y: reg_v = y_r;
      default:        reg_v = acc_r;
    endcase

    addend = (dec.post == caf_pkg::POST_SBC) ? ~mod : mod;
    sum    = {1'b0, acc_r} + {1'b0, addend} + {8'h00, p_nxt[caf_pkg::FLAG_C]};
    diff   = {1'b0, reg_v} - {1'b0, mod};

    case (dec.post)
      caf_pkg::POST_ADC, caf_pkg::POST_SBC: begin
        acc_nxt = sum[7:0];
        p_nxt[caf_pkg::FLAG_C] = sum[8];
        p_nxt[caf_pkg::FLAG_V] = ~(acc_r[7] ^ addend[7]) & (acc_r[7] ^ sum[7]);
        res = sum[7:0];
      end
      caf_pkg::POST_AND: begin acc_nxt = acc_r & mod; res = acc_r & mod; end
      caf_pkg::POST_ORA: begin acc_nxt = acc_r | mod; res = acc_r | mod; end
      caf_pkg::POST_EOR: begin acc_nxt = acc_r ^ mod; res = acc_r ^ mod; end
      caf_pkg::POST_BIT: res = acc_r & mod;
      caf_pkg::POST_CMP: begin
        p_nxt[caf_pkg::FLAG_C] = !diff[8];
        res = diff[7:0];
      end
      caf_pkg::POST_LD: begin
        res = mod;
        case (dec.reg_sel)
          caf_pkg::REG_A:  acc_nxt = mod;
          caf_pkg::REG_X:  x_nxt = mod;
          caf_pkg::REG_Y:  y_nxt = mod;
          default: begin acc_nxt = mod; x_nxt = mod; end
        endcase
      end
      caf_pkg::POST_CLF: p_nxt[pop_data.fsel] = 1'b0;
      caf_pkg::POST_SEF: p_nxt[pop_data.fsel] = 1'b1;
      default: ;
    endcase

    case (dec.post)
      caf_pkg::POST_ADC, caf_pkg::POST_SBC, caf_pkg::POST_AND, caf_pkg::POST_ORA,
      caf_pkg::POST_EOR, caf_pkg::POST_BIT, caf_pkg::POST_CMP, caf_pkg::POST_LD: begin
        p_nxt[caf_pkg::FLAG_Z] = (res == 8'h00);
        p_nxt[caf_pkg::FLAG_N] = res[7];
      end
      default: ;
    endcase
    // BIT copies operand bits 7 and 6
    if (dec.post == caf_pkg::POST_BIT) begin
      p_nxt[caf_pkg::FLAG_V] = mod[6];
      p_nxt[caf_pkg::FLAG_N] = mod[7];
    end

    we_nxt = dec.mem_wr;
    if (!dec.mem_wr) begin
      wd_nxt = 8'h00;
    end else if (dec.post == caf_pkg::POST_ST) begin
      wd_nxt = reg_v;
    end else begin
      wd_nxt = mod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 8'h00;
      x_r   <= 8'h00;
      y_r   <= 8'h00;
      p_r   <= caf_pkg::STATUS_RESET;
      ov_r  <= 1'b0;
    end else begin
      if (fire) begin
        acc_r <= acc_nxt;
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        p_r   <= p_nxt;
      end
      if (fire) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      we_r <= we_nxt;
      wd_r <= wd_nxt;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.write_enable = we_r;
  assign out_ch.write_data   = wd_r;
  assign out_ch.acc_value    = acc_r;
  assign out_ch.x_value      = x_r;
  assign out_ch.y_value      = y_r;
  assign out_ch.status_value = p_r;

endmodule

[sv/cpu_alu_and_flag_unit.sv]
// ----------------------------------------------------------------------------
// cpu_alu_and_flag_unit
// Binary-mode execute unit of an 8-bit processor with A, X, Y and status.
//
// in_ch carries one request per operation: code, memory byte and flag index.
// out_ch returns one result per request: memory write-back (enable, data)
// and A, X, Y and status after the operation, in request order.
// A request is decoded on acceptance and enters a two-entry queue; the
// execute stage takes the queue head, updates the registers and loads the
// result register in the same cycle. A request passes the queue entry and
// the result register on its way to result valid; one request per cycle is
// sustained while out_ch.ready stays high.
// When out_ch stalls, the result register holds, the queue fills and
// in_ch.ready drops once both entries are taken.
// Reset (rst_n low, synchronous) empties the queue and result register and
// sets A = X = Y = 0 and status = 0x24.
// ----------------------------------------------------------------------------
module cpu_alu_and_flag_unit (
  input  logic       clk,
  input  logic       rst_n,
  caf_in_if.sink     in_ch,
  caf_out_if.source  out_ch
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  caf_pkg::qent_t push_data, pop_data;

  caf_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  caf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  caf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

[test/tb_cpu_alu_and_flag_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpu_alu_and_flag_unit
// Self-checking bench for the binary-mode ALU and flag unit. A table of
// directed requests runs first: register extremes, every operation but STY,
// unused codes, a clear of status bit 5 and a set of bit 4. Then about
// 1400 random requests follow under three idle/stall mixes. A local model of
// A, X, Y and status predicts the untyped results, all compared in order.
// ----------------------------------------------------------------------------
module tb_cpu_alu_and_flag_unit;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_data;
    logic [7:0] acc_value;
    logic [7:0] x_value;
    logic [7:0] y_value;
    logic [7:0] status_value;
  } exec_res_t;

  typedef struct packed {
    logic [4:0] func;
    logic [7:0] operand;
    logic [2:0] fsel;
    logic       typed;
    exec_res_t  res;
  } stim_row_t;

  localparam logic [4:0] F_RSV0 = 5'd30;
  localparam logic [4:0] F_RSV1 = 5'd31;

  localparam int DIRECTED_ROWS = 33;
  localparam int ITEMS_PER_PHASE = 467;

  // rows with typed = 1 run straight after reset, so the expected registers
  // follow directly from the reset values
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{caf_pkg::F_STA, 8'h5a, 3'd0, 1'b1, '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h24}},
    '{F_RSV0, 8'hff, 3'd7, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h24}},
    '{F_RSV1, 8'hff, 3'd0, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h24}},
    '{caf_pkg::F_LDA, 8'h00, 3'd0, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h26}},
    '{caf_pkg::F_LDA, 8'hff, 3'd0, 1'b1, '{1'b0, 8'h00, 8'hff, 8'h00, 8'h00, 8'ha4}},
    '{caf_pkg::F_LDX, 8'h80, 3'd0, 1'b1, '{1'b0, 8'h00, 8'hff, 8'h80, 8'h00, 8'ha4}},
    '{caf_pkg::F_LDY, 8'h7f, 3'd0, 1'b1, '{1'b0, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h24}},
    '{caf_pkg::F_ADC, 8'h01, 3'd0, 1'b0, '0},
    '{caf_pkg::F_ADC, 8'h7f, 3'd0, 1'b0, '0},
    '{caf_pkg::F_SBC, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_AND, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_ORA, 8'h00, 3'd0, 1'b0, '0},
    '{caf_pkg::F_EOR, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_BIT, 8'hc0, 3'd0, 1'b0, '0},
    '{caf_pkg::F_CMP, 8'h80, 3'd0, 1'b0, '0},
    '{caf_pkg::F_CPX, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_CPY, 8'h00, 3'd0, 1'b0, '0},
    '{caf_pkg::F_LAX, 8'h00, 3'd0, 1'b0, '0},
    '{caf_pkg::F_ASL, 8'h80, 3'd0, 1'b0, '0},
    '{caf_pkg::F_LSR, 8'h01, 3'd0, 1'b0, '0},
    '{caf_pkg::F_ROL, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_ROR, 8'h01, 3'd0, 1'b0, '0},
    '{caf_pkg::F_INC, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_DEC, 8'h00, 3'd0, 1'b0, '0},
    '{caf_pkg::F_DCP, 8'h00, 3'd0, 1'b0, '0},
    '{caf_pkg::F_ISB, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_SLO, 8'h80, 3'd0, 1'b0, '0},
    '{caf_pkg::F_SRE, 8'h01, 3'd0, 1'b0, '0},
    '{caf_pkg::F_RLA, 8'hff, 3'd0, 1'b0, '0},
    '{caf_pkg::F_RRA, 8'h01, 3'd0, 1'b0, '0},
    '{caf_pkg::F_STX, 8'h00, 3'd0, 1'b0, '0},
    '{caf_pkg::F_CLF, 8'h00, 3'd5, 1'b0, '0},
    '{caf_pkg::F_SEF, 8'h00, 3'd4, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  caf_in_if  in_ch();
  caf_out_if out_ch();

  cpu_alu_and_flag_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0] acc_m;
  logic [7:0] x_m;
  logic [7:0] y_m;
  logic [7:0] flags_m;

  exec_res_t predicted_results[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  function automatic void set_zn(input logic [7:0] v);
    flags_m[caf_pkg::FLAG_Z] = (v == 8'h00);
    flags_m[caf_pkg::FLAG_N] = v[7];
  endfunction

  function automatic void add_carry(input logic [7:0] arg);
    logic [8:0] sum;
    sum = {1'b0, acc_m} + {1'b0, arg} + {8'h00, flags_m[caf_pkg::FLAG_C]};
    flags_m[caf_pkg::FLAG_C] = sum[8];
    flags_m[caf_pkg::FLAG_V] = ~(acc_m[7] ^ arg[7]) & (acc_m[7] ^ sum[7]);
    acc_m = sum[7:0];
    set_zn(acc_m);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    flags_m[caf_pkg::FLAG_C] = (r >= m);
    set_zn(diff);
  endfunction

  function automatic logic [7:0] shift_left(input logic [7:0] v, input logic rot);
    logic [7:0] r;
    r = {v[6:0], rot & flags_m[caf_pkg::FLAG_C]};
    flags_m[caf_pkg::FLAG_C] = v[7];
    set_zn(r);
    return r;
  endfunction

  function automatic logic [7:0] shift_right(input logic [7:0] v, input logic rot);
    logic [7:0] r;
    r = {rot & flags_m[caf_pkg::FLAG_C], v[7:1]};
    flags_m[caf_pkg::FLAG_C] = v[0];
    set_zn(r);
    return r;
  endfunction

  function automatic exec_res_t execute_op(input logic [4:0] f, input logic [7:0] m,
                                           input logic [2:0] s);
    exec_res_t  r;
    logic       we;
    logic [7:0] wd;
    we = 1'b0;
    wd = 8'h00;
    case (f)
      caf_pkg::F_ADC: add_carry(m);
      caf_pkg::F_SBC: add_carry(~m);
      caf_pkg::F_AND: begin
        acc_m = acc_m & m;
        set_zn(acc_m);
      end
      caf_pkg::F_ORA: begin
        acc_m = acc_m | m;
        set_zn(acc_m);
      end
      caf_pkg::F_EOR: begin
        acc_m = acc_m ^ m;
        set_zn(acc_m);
      end
      caf_pkg::F_BIT: begin
        set_zn(acc_m & m);
        flags_m[caf_pkg::FLAG_V] = m[6];
        flags_m[caf_pkg::FLAG_N] = m[7];
      end
      caf_pkg::F_CMP: compare_reg(acc_m, m);
      caf_pkg::F_CPX: compare_reg(x_m, m);
      caf_pkg::F_CPY: compare_reg(y_m, m);
      caf_pkg::F_LDA: begin
        acc_m = m;
        set_zn(m);
      end
      caf_pkg::F_LDX: begin
        x_m = m;
        set_zn(m);
      end
      caf_pkg::F_LDY: begin
        y_m = m;
        set_zn(m);
      end
      caf_pkg::F_LAX: begin
        acc_m = m;
        x_m = m;
        set_zn(m);
      end
      caf_pkg::F_ASL: begin
        wd = shift_left(m, 1'b0);
        we = 1'b1;
      end
      caf_pkg::F_LSR: begin
        wd = shift_right(m, 1'b0);
        we = 1'b1;
      end
      caf_pkg::F_ROL: begin
        wd = shift_left(m, 1'b1);
        we = 1'b1;
      end
      caf_pkg::F_ROR: begin
        wd = shift_right(m, 1'b1);
        we = 1'b1;
      end
      caf_pkg::F_INC: begin
        wd = m + 8'd1;
        set_zn(wd);
        we = 1'b1;
      end
      caf_pkg::F_DEC: begin
        wd = m - 8'd1;
        set_zn(wd);
        we = 1'b1;
      end
      caf_pkg::F_DCP: begin
        wd = m - 8'd1;
        we = 1'b1;
        compare_reg(acc_m, wd);
      end
      caf_pkg::F_ISB: begin
        wd = m + 8'd1;
        we = 1'b1;
        add_carry(~wd);
      end
      caf_pkg::F_SLO: begin
        wd = shift_left(m, 1'b0);
        we = 1'b1;
        acc_m = acc_m | wd;
        set_zn(acc_m);
      end
      caf_pkg::F_SRE: begin
        wd = shift_right(m, 1'b0);
        we = 1'b1;
        acc_m = acc_m ^ wd;
        set_zn(acc_m);
      end
      caf_pkg::F_RLA: begin
        wd = shift_left(m, 1'b1);
        we = 1'b1;
        acc_m = acc_m & wd;
        set_zn(acc_m);
      end
      caf_pkg::F_RRA: begin
        // add uses the carry left by the rotate
        wd = shift_right(m, 1'b1);
        we = 1'b1;
        add_carry(wd);
      end
      caf_pkg::F_STA: begin
        wd = acc_m;
        we = 1'b1;
      end
      caf_pkg::F_STX: begin
        wd = x_m;
        we = 1'b1;
      end
      caf_pkg::F_STY: begin
        wd = y_m;
        we = 1'b1;
      end
      caf_pkg::F_CLF: flags_m[s] = 1'b0;
      caf_pkg::F_SEF: flags_m[s] = 1'b1;
      default: ;
    endcase
    r.write_enable = we;
    r.write_data   = we ? wd : 8'h00;
    r.acc_value    = acc_m;
    r.x_value      = x_m;
    r.y_value      = y_m;
    r.status_value = flags_m;
    return r;
  endfunction

  task automatic send_op(input logic [4:0] f, input logic [7:0] m, input logic [2:0] s,
                         output exec_res_t pred);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.operand_byte <= m;
    in_ch.flag_select  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = execute_op(f, m, s);
  endtask

  task automatic check_byte(input string name, input logic [7:0] exp_v,
                            input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %02h, got %02h", name, exp_v, got_v);
      error_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: ready with random stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    exec_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result with no request pending");
        error_count++;
      end else begin
        e = predicted_results.pop_front();
        check_byte("write_enable", {7'd0, e.write_enable}, {7'd0, out_ch.write_enable});
        check_byte("write_data", e.write_data, out_ch.write_data);
        check_byte("acc_value", e.acc_value, out_ch.acc_value);
        check_byte("x_value", e.x_value, out_ch.x_value);
        check_byte("y_value", e.y_value, out_ch.y_value);
        check_byte("status_value", e.status_value, out_ch.status_value);
      end
    end
  end

  initial begin
    exec_res_t  pred;
    logic [4:0] f;
    int         sent;
    error_count    = 0;
    send_idle_pct  = 29;
    recv_stall_pct = 82;
    acc_m   = 8'h00;
    x_m     = 8'h00;
    y_m     = 8'h00;
    flags_m = caf_pkg::STATUS_RESET;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= caf_pkg::F_ADC;
    in_ch.operand_byte <= 8'h00;
    in_ch.flag_select  <= 3'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_op(DIRECTED[i].func, DIRECTED[i].operand, DIRECTED[i].fsel, pred);
      predicted_results.push_back(DIRECTED[i].typed ? DIRECTED[i].res : pred);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 29 : (phase == 1) ? 82 : 0;
      recv_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 29 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 15) == 0) begin
          f = 5'($urandom_range(F_RSV0, F_RSV1));
        end else begin
          f = 5'($urandom_range(caf_pkg::F_ADC, caf_pkg::F_SEF));
        end
        sent++;
        send_op(f, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), pred);
        predicted_results.push_back(pred);
      end
    end

    in_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/caf_pkg.sv
sv/caf_ifs.sv
sv/caf_front.sv
sv/caf_queue.sv
sv/caf_back.sv
sv/cpu_alu_and_flag_unit.sv
test/tb_cpu_alu_and_flag_unit.sv
